### sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Types, sizes and level decoders shared by the sensor report table.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int LEVEL_COUNT = 4;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic CMD_REPORT  = 1'b0;
    localparam logic CMD_SET_VIS = 1'b1;

    localparam logic [9:0] NO_SENSOR = 10'd1023;

    typedef struct packed {
        logic        command;
        logic [47:0] mac_address;
        logic [7:0]  msg_seq;
        logic [15:0] battery_mv;
        logic [9:0]  adc_one;
        logic [9:0]  adc_two;
        logic [9:0]  adc_three;
        logic [9:0]  adc_four;
        logic [7:0]  packet_size;
        logic [31:0] now_time;
        logic [2:0]  slot_select;
        logic        visible_value;
    } srt_report_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic [1:0]  battery_level;
        logic [2:0]  water_one;
        logic [2:0]  water_two;
        logic [2:0]  water_three;
        logic [2:0]  water_four;
        logic [31:0] last_seen;
        logic [7:0]  stored_size;
        logic        visible;
    } srt_result_t;

    // One table entry as seen at the read port.
    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  id;
        logic [31:0] last_seen;
        logic [7:0]  size;
        logic        vis;
    } srt_entry_t;

    // Write request from the sequencer to the table.
    typedef struct packed {
        logic        en;
        logic        report;
        logic        touch;
        logic        vis;
        logic [47:0] mac;
        logic [7:0]  id;
        logic [7:0]  size;
        logic [31:0] stamp;
    } srt_wr_t;

    function automatic logic [1:0] battery_code(input logic [15:0] mv);
        logic [1:0] code;
        if (mv > 16'd3700)      code = 2'd3;
        else if (mv > 16'd3600) code = 2'd2;
        else if (mv > 16'd3400) code = 2'd1;
        else                    code = 2'd0;
        return code;
    endfunction

    function automatic logic [2:0] water_code(input logic [9:0] v);
        logic [2:0] code;
        if (v == NO_SENSOR)   code = 3'd0;
        else if (v > 10'd1000) code = 3'd1;
        else if (v > 10'd900)  code = 3'd2;
        else if (v > 10'd800)  code = 3'd3;
        else if (v > 10'd600)  code = 3'd4;
        else                   code = 3'd5;
        return code;
    endfunction

endpackage

`default_nettype wire

### sv/srt_ifs.sv
// ----------------------------------------------------------------------------
// srt_ifs
// Valid/ready channels for report words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_report_if import srt_pkg::*; ();
    logic        valid;
    logic        ready;
    srt_report_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srt_result_if import srt_pkg::*; ();
    logic        valid;
    logic        ready;
    srt_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/srt_table.sv
// ----------------------------------------------------------------------------
// srt_table
// Slot storage: one read port at the sequencer's pointer, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_table
    import srt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] addr,
    input  wire srt_wr_t           wr,
    output srt_entry_t             rd
);

    logic [47:0] mac_reg   [SLOT_COUNT];
    logic [7:0]  id_reg    [SLOT_COUNT];
    logic [31:0] seen_reg  [SLOT_COUNT];
    logic [7:0]  size_reg  [SLOT_COUNT];
    logic        vis_reg   [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                mac_reg[i]  <= '0;
                id_reg[i]   <= '0;
                seen_reg[i] <= '0;
                size_reg[i] <= '0;
                vis_reg[i]  <= 1'b0;
            end
        end
        else if (wr.en)
        begin
            if (wr.report)
            begin
                mac_reg[addr]  <= wr.mac;
                id_reg[addr]   <= wr.id;
                size_reg[addr] <= wr.size;
                vis_reg[addr]  <= 1'b1;
                if (wr.touch)
                begin
                    seen_reg[addr] <= wr.stamp;
                end
            end
            else
            begin
                vis_reg[addr] <= wr.vis;
            end
        end
    end

    assign rd.mac       = mac_reg[addr];
    assign rd.id        = id_reg[addr];
    assign rd.last_seen = seen_reg[addr];
    assign rd.size      = size_reg[addr];
    assign rd.vis       = vis_reg[addr];

endmodule

`default_nettype wire

### sv/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer: walks the slots with one MAC comparator for a report, then updates one slot.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ctrl
    import srt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire srt_report_t       in_data,
    input  wire logic              res_free,
    output logic                   res_load,
    output srt_result_t            res_data,
    output logic [SLOT_W-1:0]      addr,
    output srt_wr_t                wr,
    input  wire srt_entry_t        rd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic              in_range_reg, in_range_next;
    srt_report_t       req_reg;

    logic mac_hit;
    logic slot_free;
    logic id_changed;
    logic accept;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign addr       = ptr_reg;
    assign mac_hit    = (rd.mac == req_reg.mac_address);
    assign slot_free  = (rd.mac[47:40] == 8'd0);
    assign id_changed = (rd.id != req_reg.msg_seq);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        in_range_next   = in_range_reg;
        res_load        = 1'b0;
        wr              = '0;
        res_data        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    free_found_next = 1'b0;
                    if (in_data.command == CMD_REPORT)
                    begin
                        ptr_next      = '0;
                        in_range_next = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        ptr_next      = SLOT_W'(in_data.slot_select);
                        in_range_next = (int'(in_data.slot_select) < SLOT_COUNT);
                        state_next    = ST_WRITE;
                    end
                end
            end
            ST_SCAN:
            begin
                // Stop on the first matching MAC; otherwise remember the first free slot.
                if (mac_hit)
                begin
                    state_next = ST_WRITE;
                end
                else if (ptr_reg == LAST_SLOT)
                begin
                    if (free_found_reg)
                        ptr_next = free_idx_reg;
                    else if (slot_free)
                        ptr_next = ptr_reg;
                    else
                        ptr_next = '0;
                    state_next = ST_WRITE;
                end
                else
                begin
                    if (slot_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = ptr_reg;
                    end
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                // Hold until the result register can take the word.
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (req_reg.command == CMD_REPORT)
                    begin
                        wr.en     = 1'b1;
                        wr.report = 1'b1;
                        wr.touch  = id_changed;
                        wr.mac    = req_reg.mac_address;
                        wr.id     = req_reg.msg_seq;
                        wr.size   = req_reg.packet_size;
                        wr.stamp  = req_reg.now_time;

                        res_data.slot          = 3'(ptr_reg);
                        res_data.battery_level = battery_code(req_reg.battery_mv);
                        res_data.water_one     = (LEVEL_COUNT > 0) ?
                                                 water_code(req_reg.adc_one) : 3'd0;
                        res_data.water_two     = (LEVEL_COUNT > 1) ?
                                                 water_code(req_reg.adc_two) : 3'd0;
                        res_data.water_three   = (LEVEL_COUNT > 2) ?
                                                 water_code(req_reg.adc_three) : 3'd0;
                        res_data.water_four    = (LEVEL_COUNT > 3) ?
                                                 water_code(req_reg.adc_four) : 3'd0;
                        res_data.last_seen     = id_changed ? req_reg.now_time
                                                            : rd.last_seen;
                        res_data.stored_size   = req_reg.packet_size;
                        res_data.visible       = 1'b1;
                    end
                    else
                    begin
                        res_data.slot = req_reg.slot_select;
                        if (in_range_reg)
                        begin
                            wr.en                = 1'b1;
                            wr.vis               = req_reg.visible_value;
                            res_data.last_seen   = rd.last_seen;
                            res_data.stored_size = rd.size;
                            res_data.visible     = req_reg.visible_value;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            in_range_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            in_range_reg   <= in_range_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ptr_reg) < SLOT_COUNT)
        else $error("slot pointer out of range");

    a_report_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.command == CMD_REPORT) |=>
            (state_reg == ST_SCAN && ptr_reg == '0 && !free_found_reg))
        else $error("report did not start the scan at slot 0");

    a_hit_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && mac_hit) |=>
            (state_reg == ST_WRITE && $stable(ptr_reg)))
        else $error("MAC hit did not hold the matching slot");

    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> res_load)
        else $error("table write without a result word");
`endif

endmodule

`default_nettype wire

### sv/sensor_report_table_unit.sv
// ----------------------------------------------------------------------------
// sensor_report_table_unit
// Sensor table keyed by MAC: report lookup/allocate and set-visible commands.
// ----------------------------------------------------------------------------
// The block keeps SLOT_COUNT sensor entries keyed by a 48-bit MAC. A report
// word walks the table one slot per clock through a single MAC comparator,
// stops on the first matching MAC, otherwise takes the first slot whose top
// MAC byte is zero, and overwrites slot 0 when the table is full. The slot is
// then written and a result word is built with the battery level and the
// four water levels. A report steps through accept, the comparator walk
// and the slot write; a set-visible word goes from accept straight to the
// slot write. The block takes one report word at a time; the result sits
// in an output register, so the next report word is accepted while the
// previous result waits, and the write step holds until that register is
// free. The table resets to all zeros (every slot free) at once, with no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_report_table_unit
    import srt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    srt_report_if.sink    report,
    srt_result_if.source  result
);

    srt_wr_t           wr;
    srt_entry_t        rd;
    logic [SLOT_W-1:0] addr;
    logic              res_load;
    logic              res_free;
    srt_result_t       res_data;

    logic              res_valid_reg;
    srt_result_t       res_data_reg;

    // Output register is free when empty or being drained this cycle.
    assign res_free = !res_valid_reg || result.ready;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (report.ready),
        .in_data  (report.data),
        .res_free (res_free),
        .res_load (res_load),
        .res_data (res_data),
        .addr     (addr),
        .wr       (wr),
        .rd       (rd)
    );

    srt_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (addr),
        .wr    (wr),
        .rd    (rd)
    );

    // Hold the result word until taken; load a new one when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_data;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> res_free)
        else $error("result word loaded over a pending word");

    a_load_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (result.valid && result.data == $past(res_data)))
        else $error("loaded result word not presented");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !report.ready)
        else $error("report word taken during a slot write");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor report table unit.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the sensor table and works out each
// result word as report words are accepted. Directed tests come first: the
// battery and water thresholds, a fresh slot whose id equals the stale one,
// filling and overflowing the table, and the set-visible command. Random
// traffic follows. It is mostly well-formed report streams from a small
// pool of sensors with advancing ids, mixed with stray MACs and set-visible
// words, under random idling on both sides, a stretch with no idling, and
// pauses that let the table drain.
// ----------------------------------------------------------------------------
module tb;
    import srt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 6;
    localparam int IDLE_PCT     = 26;
    localparam int MAC_POOL     = 12;
    localparam int ADC_STEPS    = 11;

    // Battery and water thresholds of the display icons.
    localparam logic [15:0] BATT_FULL_MV = 16'd3700;
    localparam logic [15:0] BATT_MID_MV  = 16'd3600;
    localparam logic [15:0] BATT_LOW_MV  = 16'd3400;
    localparam logic [9:0]  WATER_DRY    = 10'd1000;
    localparam logic [9:0]  WATER_DAMP   = 10'd900;
    localparam logic [9:0]  WATER_MOIST  = 10'd800;
    localparam logic [9:0]  WATER_WET    = 10'd600;

    logic clk;
    logic rst_n;

    srt_report_if report_ch ();
    srt_result_if result_ch ();

    sensor_report_table_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report_ch),
        .result (result_ch)
    );

    // Scoreboard copy of the sensor table.
    logic [47:0] mac_tab  [SLOT_COUNT];
    logic [7:0]  id_tab   [SLOT_COUNT];
    logic [31:0] seen_tab [SLOT_COUNT];
    logic [7:0]  size_tab [SLOT_COUNT];
    logic        vis_tab  [SLOT_COUNT];

    srt_result_t pending_results[$];
    srt_result_t oldest;

    logic [47:0] mac_pool [MAC_POOL];
    logic [7:0]  pool_id  [MAC_POOL];

    int errors;
    int n_reports;
    int n_set_vis;
    int n_evictions;
    int n_checked;
    int cycles;
    bit steady;

    // ------------------------------------------------------------------------
    // Clock, watchdog and result-side backpressure
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bail out if the run hangs; the limit is many times the slowest run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d result words still outstanding", $time,
                     pending_results.size());
            $display("[sensor_report_table_unit] ERROR");
            $finish;
        end
    end

    // Stall the receiver at random, except during the steady stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------
    function automatic logic [1:0] battery_bars(input logic [15:0] mv);
        if (mv > BATT_FULL_MV)
            return 2'd3;
        if (mv > BATT_MID_MV)
            return 2'd2;
        if (mv > BATT_LOW_MV)
            return 2'd1;
        return 2'd0;
    endfunction

    // Map one ADC reading to its water level; an absent probe maps to level zero.
    function automatic logic [2:0] water_depth(input int lane, input logic [9:0] adc);
        if (lane >= LEVEL_COUNT || adc == NO_SENSOR)
            return 3'd0;
        if (adc > WATER_DRY)
            return 3'd1;
        if (adc > WATER_DAMP)
            return 3'd2;
        if (adc > WATER_MOIST)
            return 3'd3;
        if (adc > WATER_WET)
            return 3'd4;
        return 3'd5;
    endfunction

    function automatic void clear_table();
        int i;
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            mac_tab[i]  = '0;
            id_tab[i]   = '0;
            seen_tab[i] = '0;
            size_tab[i] = '0;
            vis_tab[i]  = 1'b0;
        end
    endfunction

    // Apply one accepted word to the table copy and return the result word.
    function automatic srt_result_t table_update(input srt_report_t w);
        srt_result_t r;
        int s;
        int i;
        r = '0;
        if (w.command == CMD_REPORT)
        begin
            // Hit on the MAC first, else the first free slot, else evict slot 0.
            s = -1;
            for (i = 0; i < SLOT_COUNT; i++)
                if (s < 0 && mac_tab[i] == w.mac_address)
                    s = i;
            for (i = 0; i < SLOT_COUNT; i++)
                if (s < 0 && mac_tab[i][47:40] == 8'd0)
                    s = i;
            if (s < 0)
            begin
                s = 0;
                n_evictions++;
            end
            // The stamp moves only when the id differs from the stored one.
            if (id_tab[s] != w.msg_seq)
                seen_tab[s] = w.now_time;
            mac_tab[s]  = w.mac_address;
            id_tab[s]   = w.msg_seq;
            size_tab[s] = w.packet_size;
            vis_tab[s]  = 1'b1;
            r.slot          = 3'(s);
            r.battery_level = battery_bars(w.battery_mv);
            r.water_one     = water_depth(0, w.adc_one);
            r.water_two     = water_depth(1, w.adc_two);
            r.water_three   = water_depth(2, w.adc_three);
            r.water_four    = water_depth(3, w.adc_four);
            r.last_seen     = seen_tab[s];
            r.stored_size   = size_tab[s];
            r.visible       = vis_tab[s];
            n_reports++;
        end
        else
        begin
            s = int'(w.slot_select);
            r.slot = w.slot_select;
            if (s < SLOT_COUNT)
            begin
                vis_tab[s]    = w.visible_value;
                r.last_seen   = seen_tab[s];
                r.stored_size = size_tab[s];
                r.visible     = vis_tab[s];
            end
            n_set_vis++;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare every accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word for slot %0d with nothing expected", $time,
                         result_ch.data.slot);
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("slot", 32'(oldest.slot), 32'(result_ch.data.slot));
                check_field("battery_level", 32'(oldest.battery_level),
                            32'(result_ch.data.battery_level));
                check_field("water_one", 32'(oldest.water_one),
                            32'(result_ch.data.water_one));
                check_field("water_two", 32'(oldest.water_two),
                            32'(result_ch.data.water_two));
                check_field("water_three", 32'(oldest.water_three),
                            32'(result_ch.data.water_three));
                check_field("water_four", 32'(oldest.water_four),
                            32'(result_ch.data.water_four));
                check_field("last_seen", oldest.last_seen, result_ch.data.last_seen);
                check_field("stored_size", 32'(oldest.stored_size),
                            32'(result_ch.data.stored_size));
                check_field("visible", 32'(oldest.visible), 32'(result_ch.data.visible));
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Idle at random, then hold the word until it is taken. Valid stays high
    // after the handshake so a following word goes out back to back.
    task automatic send_word(input srt_report_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            report_ch.valid <= 1'b0;
            @(posedge clk);
        end
        report_ch.valid <= 1'b1;
        report_ch.data  <= w;
        @(posedge clk);
        while (!report_ch.ready)
            @(posedge clk);
        pending_results.push_back(table_update(w));
    endtask

    // Drop valid and hold until every expected result word is back.
    task automatic wait_drained();
        report_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic srt_report_t report_word(input logic [47:0] mac, input logic [7:0] id,
                                                input logic [15:0] mv, input logic [39:0] adcs,
                                                input logic [7:0] size, input logic [31:0] stamp);
        srt_report_t w;
        w = '0;
        w.command     = CMD_REPORT;
        w.mac_address = mac;
        w.msg_seq     = id;
        w.battery_mv  = mv;
        {w.adc_one, w.adc_two, w.adc_three, w.adc_four} = adcs;
        w.packet_size = size;
        w.now_time    = stamp;
        return w;
    endfunction

    function automatic srt_report_t set_vis_word(input logic [2:0] slot, input logic vis);
        srt_report_t w;
        w = '0;
        w.command       = CMD_SET_VIS;
        w.slot_select   = slot;
        w.visible_value = vis;
        return w;
    endfunction

    // Readings around every water threshold, with the no-sensor code first.
    function automatic logic [9:0] adc_step(input int k);
        logic [9:0] steps [ADC_STEPS];
        steps = '{NO_SENSOR, 10'd1022, 10'd1001, 10'd1000, 10'd901, 10'd900,
                  10'd801, 10'd800, 10'd601, 10'd600, 10'd0};
        return steps[k % ADC_STEPS];
    endfunction

    function automatic logic [9:0] random_adc();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return NO_SENSOR;
        if (pick < 4)
            return 10'($urandom_range(595, 1023));
        return 10'($urandom_range(0, 1023));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // A fresh slot compares against the id left at reset, so id 0 keeps the
    // stamp at zero; a new id then moves it, a repeated id does not.
    task automatic test_stale_id_on_fresh_slot();
        send_word(report_word(48'hA1_00_00_00_00_01, 8'd0, 16'd3800, {4{10'd500}},
                              8'd16, 32'h0000_1000));
        send_word(report_word(48'hA1_00_00_00_00_01, 8'd1, 16'd3800, {4{10'd500}},
                              8'd17, 32'h0000_2000));
        send_word(report_word(48'hA1_00_00_00_00_01, 8'd1, 16'd3800, {4{10'd500}},
                              8'd18, 32'h0000_3000));
    endtask

    // Walk the battery thresholds and sweep the water thresholds on all lanes.
    task automatic test_battery_and_water_levels();
        logic [15:0] mv_steps [8];
        int k;
        mv_steps = '{16'd0, 16'd3400, 16'd3401, 16'd3600, 16'd3601, 16'd3700,
                     16'd3701, 16'hFFFF};
        for (k = 0; k < 8; k++)
            send_word(report_word(48'hA1_00_00_00_00_01, 8'(k + 2), mv_steps[k],
                                  {adc_step(4 * k), adc_step(4 * k + 1),
                                   adc_step(4 * k + 2), adc_step(4 * k + 3)},
                                  8'(k), 32'(k * 32'h0101_0101)));
    endtask

    // A MAC with a zero top byte leaves its slot looking free, so the next
    // new MAC lands on it. Fill the rest, then overflow into slot 0.
    task automatic test_table_full();
        int k;
        send_word(report_word(48'h00_12_34_56_78_9A, 8'd5, 16'd3500, {4{10'd700}},
                              8'd40, 32'h0000_4000));
        for (k = 0; k < SLOT_COUNT - 1; k++)
            send_word(report_word({8'hB0 + 8'(k), 40'h55_AA_55_AA_00 + 40'(k)}, 8'(k + 9),
                                  16'd3650, {4{10'd850}}, 8'(k + 60),
                                  32'h0001_0000 + 32'(k)));
        send_word(report_word(48'hFFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, {4{10'h3FF}},
                              8'hFF, 32'hFFFF_FFFF));
    endtask

    // Clear and set flags, then a report on a hidden slot shows it again.
    task automatic test_set_visible();
        send_word(set_vis_word(3'd0, 1'b0));
        send_word(set_vis_word(3'd7, 1'b1));
        send_word(set_vis_word(3'd3, 1'b0));
        send_word(report_word({8'hB2, 40'h55_AA_55_AA_02}, 8'd11, 16'd3450,
                              {4{10'd0}}, 8'd99, 32'h0002_0000));
        wait_drained();
    endtask

    // Mostly report streams from the sensor pool with advancing ids; the
    // rest are stray MACs and set-visible words. Drain every pause_every
    // words when asked.
    task automatic random_traffic(input int count, input int pause_every);
        srt_report_t w;
        int k;
        int p;
        int mode;
        for (k = 0; k < count; k++)
        begin
            if (pause_every > 0 && k > 0 && k % pause_every == 0)
                wait_drained();
            // Fill every field so unused ones toggle too.
            w.command       = CMD_REPORT;
            w.mac_address   = {16'($urandom), 32'($urandom)};
            w.msg_seq       = 8'($urandom);
            w.battery_mv    = $urandom_range(1) ? 16'($urandom_range(3300, 3800))
                                                : 16'($urandom);
            w.adc_one       = random_adc();
            w.adc_two       = random_adc();
            w.adc_three     = random_adc();
            w.adc_four      = random_adc();
            w.packet_size   = 8'($urandom);
            w.now_time      = 32'($urandom);
            w.slot_select   = 3'($urandom_range(7));
            w.visible_value = 1'($urandom);
            if ($urandom_range(99) < 18)
                w.command = CMD_SET_VIS;
            else if ($urandom_range(9) != 0)
            begin
                p = $urandom_range(MAC_POOL - 1);
                w.mac_address = mac_pool[p];
                mode = $urandom_range(99);
                if (mode < 70)
                    w.msg_seq = pool_id[p] + 8'd1;
                else if (mode < 85)
                    w.msg_seq = pool_id[p];
                pool_id[p] = w.msg_seq;
            end
            else if ($urandom_range(3) == 0)
                w.mac_address[47:40] = 8'd0;
            send_word(w);
        end
    endtask

    task automatic test_random_mix();
        random_traffic(600, 0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        random_traffic(300, 0);
        steady = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        random_traffic(350, 50);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int p;
        errors      = 0;
        n_reports   = 0;
        n_set_vis   = 0;
        n_evictions = 0;
        n_checked   = 0;
        cycles      = 0;
        steady      = 1'b0;
        rst_n       = 1'b0;
        report_ch.valid <= 1'b0;
        report_ch.data  <= '0;
        clear_table();
        // Two pool sensors carry a zero top byte and keep their slot free.
        for (p = 0; p < MAC_POOL; p++)
        begin
            mac_pool[p] = {16'($urandom), 32'($urandom)};
            if (p < 2)
                mac_pool[p][47:40] = 8'd0;
            else if (mac_pool[p][47:40] == 8'd0)
                mac_pool[p][47:40] = 8'h5A;
            pool_id[p] = 8'($urandom);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stale_id_on_fresh_slot();
        test_battery_and_water_levels();
        test_table_full();
        test_set_visible();
        test_random_mix();
        test_back_to_back();
        test_pause_until_drained();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d reports, %0d set-visible words, %0d slot 0 evictions;",
                 n_reports, n_set_vis, n_evictions);
        $display("%0d result words compared, %0d mismatches.", n_checked, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("[sensor_report_table_unit] OK");
        else
            $display("[sensor_report_table_unit] ERROR");
        $finish;
    end

endmodule

### sensor_report_table_unit.f
sv/srt_pkg.sv
sv/srt_ifs.sv
sv/srt_table.sv
sv/srt_ctrl.sv
sv/sensor_report_table_unit.sv
tb/tb.sv
